// ----- rtl/sfd_pkg.sv -----
// Shared types and constants for the sum-checked frame deframer.
`default_nettype none
package sfd_pkg;

    localparam logic [7:0]  START_BYTE = 8'h68;
    localparam logic [7:0]  END_BYTE   = 8'h16;
    localparam logic [16:0] HEADER_LEN = 17'd11;
    localparam logic [16:0] LEN_LO_IDX = 17'd9;
    localparam logic [16:0] LEN_HI_IDX = 17'd10;
    localparam logic [15:0] MAX_LEN_RESET = 16'd256;

    localparam logic [2:0] ST_NONE = 3'd0;
    localparam logic [2:0] ST_DONE = 3'd1;
    localparam logic [2:0] ST_LEN  = 3'd2;
    localparam logic [2:0] ST_CS   = 3'd3;
    localparam logic [2:0] ST_END  = 3'd4;

    localparam int TDATA_W = 48;
    localparam int TUSER_W = 4;

    typedef struct packed {
        logic [7:0]  frame_byte;
        logic        byte_in_frame;
        logic [16:0] byte_index;
        logic [2:0]  status;
        logic [16:0] frame_length;
    } t_result;

endpackage
`default_nettype wire

// ----- rtl/sfd_core.sv -----
// Frame tracking state and per-byte result logic.
`default_nettype none
module sfd_core
    import sfd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [15:0] i_cfg_wr_data,
    input  wire logic        i_step,
    input  wire logic [7:0]  i_byte,
    output t_result          o_result
);

    logic        r_in_frame, n_in_frame;
    logic [16:0] r_pos, n_pos;
    logic [7:0]  r_sum, n_sum;
    logic [7:0]  r_len_low, n_len_low;
    logic [16:0] r_data_end, n_data_end;
    logic [15:0] r_max_len;

    logic [15:0] len;
    logic [16:0] pos_inc;
    logic [16:0] end_pos;

    assign len     = {i_byte, r_len_low};
    assign pos_inc = r_pos + 17'd1;
    assign end_pos = r_data_end + 17'd1;

    always_comb begin
        n_in_frame = r_in_frame;
        n_pos      = r_pos;
        n_sum      = r_sum;
        n_len_low  = r_len_low;
        n_data_end = r_data_end;
        o_result.frame_byte    = i_byte;
        o_result.byte_in_frame = 1'b0;
        o_result.byte_index    = '0;
        o_result.status        = ST_NONE;
        o_result.frame_length  = '0;

        if (!r_in_frame) begin
            if (i_byte == START_BYTE) begin
                n_in_frame = 1'b1;
                o_result.byte_in_frame = 1'b1;
                n_pos      = 17'd1;
                n_sum      = i_byte;
                n_data_end = HEADER_LEN;
            end
        end else if (r_pos < HEADER_LEN) begin
            o_result.byte_index    = r_pos;
            o_result.byte_in_frame = 1'b1;
            n_sum = r_sum + i_byte;
            n_pos = pos_inc;
            if (r_pos == LEN_LO_IDX) begin
                n_len_low = i_byte;
            end else if (r_pos == LEN_HI_IDX) begin
                if (len > r_max_len) begin
                    n_in_frame = 1'b0;
                    o_result.status = ST_LEN;
                end else begin
                    n_data_end = {1'b0, len} + HEADER_LEN;
                end
            end
        end else if (r_pos < r_data_end) begin
            o_result.byte_index    = r_pos;
            o_result.byte_in_frame = 1'b1;
            n_sum = r_sum + i_byte;
            n_pos = pos_inc;
        end else if (r_pos == r_data_end) begin
            // checksum byte: a mismatch is not taken into the frame
            o_result.byte_index = r_pos;
            if (r_sum == i_byte) begin
                o_result.byte_in_frame = 1'b1;
                n_pos = pos_inc;
            end else begin
                n_in_frame = 1'b0;
                o_result.status = ST_CS;
            end
        end else if (r_pos == end_pos) begin
            o_result.byte_index    = r_pos;
            o_result.byte_in_frame = 1'b1;
            n_pos      = pos_inc;
            n_in_frame = 1'b0;
            if (i_byte == END_BYTE) begin
                o_result.status       = ST_DONE;
                o_result.frame_length = pos_inc;
            end else begin
                o_result.status = ST_END;
            end
        end else begin
            // past the frame end, only reachable through a corrupt state
            o_result.byte_index = r_pos;
            n_in_frame = 1'b0;
            o_result.status = ST_LEN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_pos      <= '0;
            r_sum      <= '0;
            r_len_low  <= '0;
            r_data_end <= HEADER_LEN;
            r_max_len  <= MAX_LEN_RESET;
        end else begin
            if (i_cfg_wr_en) begin
                r_max_len <= i_cfg_wr_data;
            end
            if (i_step) begin
                r_in_frame <= n_in_frame;
                r_pos      <= n_pos;
                r_sum      <= n_sum;
                r_len_low  <= n_len_low;
                r_data_end <= n_data_end;
            end
        end
    end

endmodule
`default_nettype wire

// ----- rtl/sfd_out_reg.sv -----
// Result register with valid/ready handshake toward the output stream.
`default_nettype none
module sfd_out_reg
    import sfd_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_load,
    input  wire t_result  i_result,
    input  wire logic     i_ready,
    output logic          o_valid,
    output logic          o_can_load,
    output t_result       o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_can_load = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_result   = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_can_load && i_load) begin
            r_result <= i_result;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/sum_checked_frame_deframer_unit.sv -----
// Top level of the sum-checked frame deframer.
//
//  channel  dir  width  contents
//  s_axis   in   8      rx_byte
//  m_axis   out  48+4   tdata: frame_byte, byte_index, frame_length; tuser: flag, status
//  cfg      in   16     max_payload_len write
//
// One byte per cycle while m_axis_tready is high; each byte is held first in the input
// register and then in the result register before it appears on m_axis.
// The frame state updates when a byte moves from the input register to the result
// register, so a stall on m_axis holds both stages and no byte is lost.
// Synchronous active-low reset clears both valid flags and the frame state and
// sets max_payload_len to 256.
`default_nettype none
module sum_checked_frame_deframer_unit
    import sfd_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_wr_en,
    input  wire logic [15:0]        i_cfg_wr_data,
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire logic [7:0]         s_axis_tdata,   // [7:0] rx_byte
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    output logic [TDATA_W-1:0]      m_axis_tdata,   // [7:0] frame_byte, [24:8] byte_index,
                                                    // [41:25] frame_length, [47:42] zero
    output logic [TUSER_W-1:0]      m_axis_tuser    // [0] byte_in_frame, [3:1] status
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       can_load;
    logic       step;
    t_result    core_result;
    t_result    out_result;

    assign step          = r_in_valid && can_load;
    assign s_axis_tready = !r_in_valid || can_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    sfd_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_step        (step),
        .i_byte        (r_in_byte),
        .o_result      (core_result)
    );

    sfd_out_reg u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (r_in_valid),
        .i_result   (core_result),
        .i_ready    (m_axis_tready),
        .o_valid    (m_axis_tvalid),
        .o_can_load (can_load),
        .o_result   (out_result)
    );

    assign m_axis_tdata = {6'd0, out_result.frame_length, out_result.byte_index,
                           out_result.frame_byte};
    assign m_axis_tuser = {out_result.status, out_result.byte_in_frame};

endmodule
`default_nettype wire

// ----- rtl/sfd_checker.sv -----
// Port-level checks for the deframer and their bind to the top level.
`default_nettype none
module sfd_checker
    import sfd_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               m_axis_tvalid,
    input wire logic               m_axis_tready,
    input wire logic [TDATA_W-1:0] m_axis_tdata,
    input wire logic [TUSER_W-1:0] m_axis_tuser
);

    logic [2:0] status;
    logic       taken;

    assign status = m_axis_tuser[3:1];
    assign taken  = m_axis_tuser[0];

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    a_done_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && status == ST_DONE |->
            taken && m_axis_tdata[7:0] == END_BYTE && m_axis_tdata[41:25] != 17'd0)
        else $error("frame complete without taken end byte");

    a_cs_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && status == ST_CS |-> !taken)
        else $error("checksum error byte marked as taken");

    a_len_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && status != ST_DONE |-> m_axis_tdata[41:25] == 17'd0)
        else $error("frame length set without completion");

    a_hunt_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !taken && status == ST_NONE |-> m_axis_tdata[24:8] == 17'd0)
        else $error("dropped byte carries an index");

endmodule

bind sum_checked_frame_deframer_unit sfd_checker u_sfd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire

// ----- verif/testbench.sv -----
// Self-checking testbench for the sum-checked frame deframer: byte stream in, per-byte status out.
`default_nettype none
module testbench;
    import sfd_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;

    typedef enum {F_NONE, F_CHECKSUM, F_END, F_LENGTH, F_CUT} t_fault;

    // Tracks the frame state per accepted byte and holds the results still to come.
    class frame_tracker;
        logic [15:0] max_len;
        bit          in_frame;
        logic [16:0] pos;
        logic [7:0]  sum;
        logic [7:0]  len_lo;
        logic [16:0] data_end;
        t_result     pending_results[$];
        int          bad_count;

        function new();
            max_len   = MAX_LEN_RESET;
            in_frame  = 1'b0;
            pos       = '0;
            sum       = '0;
            len_lo    = '0;
            data_end  = HEADER_LEN;
            bad_count = 0;
        endfunction

        function void take_byte(logic [7:0] b);
            t_result     r;
            logic [16:0] len;
            r.frame_byte    = b;
            r.byte_in_frame = 1'b0;
            r.byte_index    = '0;
            r.status        = ST_NONE;
            r.frame_length  = '0;
            if (!in_frame) begin
                if (b == START_BYTE) begin
                    in_frame        = 1'b1;
                    r.byte_in_frame = 1'b1;
                    pos             = 17'd1;
                    sum             = b;
                    data_end        = HEADER_LEN;
                end
            end else if (pos < HEADER_LEN) begin
                r.byte_index    = pos;
                r.byte_in_frame = 1'b1;
                sum             = sum + b;
                pos             = pos + 17'd1;
                if (r.byte_index == LEN_LO_IDX) begin
                    len_lo = b;
                end else if (r.byte_index == LEN_HI_IDX) begin
                    len = {1'b0, b, len_lo};
                    if (len > {1'b0, max_len}) begin
                        in_frame = 1'b0;
                        r.status = ST_LEN;
                    end else begin
                        data_end = len + HEADER_LEN;
                    end
                end
            end else if (pos < data_end) begin
                r.byte_index    = pos;
                r.byte_in_frame = 1'b1;
                sum             = sum + b;
                pos             = pos + 17'd1;
            end else if (pos == data_end) begin
                r.byte_index = pos;
                if (sum == b) begin
                    r.byte_in_frame = 1'b1;
                    pos             = pos + 17'd1;
                end else begin
                    in_frame = 1'b0;
                    r.status = ST_CS;
                end
            end else if (pos == data_end + 17'd1) begin
                r.byte_index    = pos;
                r.byte_in_frame = 1'b1;
                pos             = pos + 17'd1;
                in_frame        = 1'b0;
                if (b == END_BYTE) begin
                    r.status       = ST_DONE;
                    r.frame_length = pos;
                end else begin
                    r.status = ST_END;
                end
            end else begin
                r.byte_index = pos;
                in_frame     = 1'b0;
                r.status     = ST_LEN;
            end
            pending_results.push_back(r);
        endfunction

        function void match_result(t_result got);
            t_result want;
            if (pending_results.size() == 0) begin
                bad_count++;
                $display("%0t: unexpected result %h", $time, got);
                return;
            end
            want = pending_results.pop_front();
            if (got !== want) begin
                bad_count++;
                if (got.frame_byte !== want.frame_byte)
                    $display("%0t: frame_byte expected %h actual %h",
                             $time, want.frame_byte, got.frame_byte);
                if (got.byte_in_frame !== want.byte_in_frame)
                    $display("%0t: byte_in_frame expected %b actual %b",
                             $time, want.byte_in_frame, got.byte_in_frame);
                if (got.byte_index !== want.byte_index)
                    $display("%0t: byte_index expected %0d actual %0d",
                             $time, want.byte_index, got.byte_index);
                if (got.status !== want.status)
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, got.status);
                if (got.frame_length !== want.frame_length)
                    $display("%0t: frame_length expected %0d actual %0d",
                             $time, want.frame_length, got.frame_length);
            end
        endfunction
    endclass

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                i_cfg_wr_en   = 1'b0;
    logic [15:0]         i_cfg_wr_data = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [7:0]          s_axis_tdata  = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]  m_axis_tdata;
    logic [TUSER_W-1:0]  m_axis_tuser;

    frame_tracker tracker = new();
    bit           steady = 1'b0;
    int unsigned  bytes_sent = 0;
    int unsigned  cycle_count = 0;
    t_result      seen;

    sum_checked_frame_deframer_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Result side: check each transfer, stall at random unless in the steady stretch.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen.frame_byte    = m_axis_tdata[7:0];
            seen.byte_index    = m_axis_tdata[24:8];
            seen.frame_length  = m_axis_tdata[41:25];
            seen.byte_in_frame = m_axis_tuser[0];
            seen.status        = m_axis_tuser[3:1];
            tracker.match_result(seen);
        end
        m_axis_tready <= steady || ($urandom_range(99) >= 24);
    end

    // Valid stays high after a transfer, so back-to-back bytes go through without a gap.
    task automatic send_byte(input logic [7:0] b);
        if (!steady && $urandom_range(99) < 24) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < 24);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        tracker.take_byte(b);
        bytes_sent++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (tracker.pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_max_len(input logic [15:0] value);
        drain();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        tracker.max_len = value;
    endtask

    task automatic send_frame(input int unsigned len, input t_fault fault);
        logic [7:0]  bytes[$];
        logic [7:0]  cs;
        logic [7:0]  tail;
        int unsigned stop;
        bytes.push_back(START_BYTE);
        repeat (8) bytes.push_back(8'($urandom_range(255)));
        bytes.push_back(len[7:0]);
        bytes.push_back(len[15:8]);
        if (fault != F_LENGTH) begin
            repeat (len) bytes.push_back(8'($urandom_range(255)));
            cs = '0;
            foreach (bytes[i]) cs = cs + bytes[i];
            if (fault == F_CHECKSUM) begin
                // a wrong checksum that looks like a start byte must not reopen a frame
                if ($urandom_range(3) == 0 && cs != START_BYTE)
                    cs = START_BYTE;
                else
                    cs = cs + 8'($urandom_range(1, 255));
            end
            bytes.push_back(cs);
            tail = END_BYTE;
            if (fault == F_END) begin
                tail = ($urandom_range(3) == 0) ? START_BYTE : 8'($urandom_range(255));
                if (tail == END_BYTE) tail = 8'hFF;
            end
            bytes.push_back(tail);
        end
        stop = (fault == F_CUT) ? $urandom_range(1, bytes.size() - 1) : bytes.size();
        for (int i = 0; i < stop; i++) send_byte(bytes[i]);
    endtask

    task automatic run_phase(input int unsigned goal);
        int unsigned pick;
        int unsigned len;
        int unsigned lim;
        logic [7:0]  noise;
        t_fault      fault;
        while (bytes_sent < goal) begin
            repeat ($urandom_range(2)) begin
                noise = 8'($urandom_range(255));
                if (noise == START_BYTE && $urandom_range(9) != 0) noise = 8'h00;
                send_byte(noise);
            end
            lim  = (tracker.max_len < 24) ? tracker.max_len : 24;
            len  = $urandom_range(lim);
            pick = $urandom_range(99);
            if (pick < 8 && tracker.max_len <= 64)
                len = tracker.max_len;
            else if (pick < 12)
                len = $urandom_range((tracker.max_len < 200) ? tracker.max_len : 200);
            pick = $urandom_range(99);
            if (pick < 70)
                fault = F_NONE;
            else if (pick < 78)
                fault = F_CHECKSUM;
            else if (pick < 86)
                fault = F_END;
            else if (pick < 93)
                fault = F_LENGTH;
            else
                fault = F_CUT;
            if (fault == F_LENGTH) begin
                if (tracker.max_len == 16'hFFFF)
                    fault = F_NONE;
                else if ($urandom_range(3) == 0)
                    len = 16'hFFFF;
                else
                    len = $urandom_range(tracker.max_len + 1, 16'hFFFF);
            end
            send_frame(len, fault);
            if ($urandom_range(99) < 2) drain();
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // extremes while hunting, an empty good frame, an oversize length
        send_byte(8'h00);
        send_byte(8'hFF);
        send_frame(0, F_NONE);
        send_frame(16'hFFFF, F_LENGTH);

        run_phase(330);
        write_max_len(16'd0);
        run_phase(600);
        write_max_len(16'hFFFF);
        steady = 1'b1;
        run_phase(900);
        steady = 1'b0;
        write_max_len(16'd3);
        run_phase(1200);
        write_max_len(16'($urandom_range(1000, 65534)));
        run_phase(1500);
        write_max_len(16'd40);
        run_phase(1850);

        drain();
        if (tracker.bad_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
`default_nettype wire
